@@ src/lcnc_pkg.sv @@
`default_nettype none

package lcnc_pkg;

    localparam int CARD_W         = 63;
    localparam int NUM_DIGITS     = 19;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int COUNT_W        = 5;
    localparam int BITS_PER_STAGE = 7;
    localparam int DD_STAGES      = CARD_W / BITS_PER_STAGE;
    localparam int HALF_DIGITS    = 10;
    localparam int PSUM_W         = 7;
    localparam int SUM_W          = 8;

    localparam logic [1:0] CLASS_INVALID = 2'd0;
    localparam logic [1:0] CLASS_AMEX    = 2'd1;
    localparam logic [1:0] CLASS_MC      = 2'd2;
    localparam logic [1:0] CLASS_VISA    = 2'd3;

    localparam logic [COUNT_W-1:0] LEN_AMEX    = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_MC      = 5'd16;
    localparam logic [COUNT_W-1:0] LEN_VISA_S  = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_VISA_L  = 5'd16;

    typedef logic [BCD_W-1:0]   bcd_t;
    typedef logic [CARD_W-1:0]  card_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    function automatic bcd_t dd_adjust(input bcd_t b);
        bcd_t r;
        r = b;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (b[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                r[i*DIGIT_W +: DIGIT_W] = b[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return r;
    endfunction

    function automatic digit_t luhn_fold(input digit_t d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[DIGIT_W-1:0];
    endfunction

    function automatic digit_t get_digit(input bcd_t b, input logic [COUNT_W-1:0] idx);
        digit_t d;
        d = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (idx == COUNT_W'(i)) begin
                d = b[i*DIGIT_W +: DIGIT_W];
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ src/lcnc_dd_stage.sv @@
`default_nettype none

module lcnc_dd_stage
    import lcnc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic adv,
    input  wire logic vld_in,
    input  wire bcd_t bcd_in,
    input  wire card_t bin_in,
    output logic      vld_reg,
    output bcd_t      bcd_reg,
    output card_t     bin_reg
);

    bcd_t  bcd_next;
    card_t bin_next;

    always_comb begin
        logic [BCD_W+CARD_W-1:0] t;
        t = {bcd_in, bin_in};
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            t[BCD_W+CARD_W-1:CARD_W] = dd_adjust(t[BCD_W+CARD_W-1:CARD_W]);
            t = t << 1;
        end
        bcd_next = t[BCD_W+CARD_W-1:CARD_W];
        bin_next = t[CARD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

endmodule

`default_nettype wire

@@ src/luhn_card_number_classifier_unit.sv @@
// Luhn card number classifier.
// Input channel: s_valid/s_ready carry one request, a 63-bit unsigned card
// number on s_card_number. Result channel: m_valid/m_ready carry the card
// class, the Luhn check flag and the decimal digit count for that request.
// The number is converted to 19 BCD digits by a nine-stage double-dabble
// pipeline, seven bits per stage; one stage then counts digits and forms two
// partial Luhn sums, and the output stage adds them, reduces mod 10 and
// classifies by leading digits and length.
// A request passes the nine double-dabble stages, the digit-count stage and
// the output stage to m_valid. Throughput: one request per cycle unless stalled.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles fill even while the output is held.
// When the receiver holds m_ready low the result stays unchanged, the
// pipeline fills behind it and s_ready drops only once every stage is full.
// Reset (aresetn low at a clock edge) empties the pipeline; no result is lost
// or repeated across a stall.
`default_nettype none

module luhn_card_number_classifier_unit
    import lcnc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CARD_W-1:0] s_card_number,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_card_class,
    output logic                   m_checksum_ok,
    output logic [COUNT_W-1:0]     m_digit_count
);

    logic  dd_vld [DD_STAGES];
    bcd_t  dd_bcd [DD_STAGES];
    card_t dd_bin [DD_STAGES];
    logic  dd_adv [DD_STAGES];

    logic                s9_vld_reg;
    bcd_t                s9_bcd_reg;
    logic [COUNT_W-1:0]  s9_count_reg;
    logic [PSUM_W-1:0]   s9_sum_lo_reg;
    logic [PSUM_W-1:0]   s9_sum_hi_reg;
    logic                s9_adv;

    logic                out_vld_reg;
    logic [1:0]          out_class_reg;
    logic                out_ok_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_adv;

    logic [COUNT_W-1:0]  count_next;
    logic [PSUM_W-1:0]   sum_lo_next;
    logic [PSUM_W-1:0]   sum_hi_next;
    logic [1:0]          class_next;
    logic                ok_next;

    assign out_adv = !out_vld_reg || m_ready;
    assign s9_adv  = !s9_vld_reg || out_adv;

    genvar g;
    generate
        for (g = 0; g < DD_STAGES; g++) begin : g_dd
            if (g == DD_STAGES - 1) begin : g_last
                assign dd_adv[g] = !dd_vld[g] || s9_adv;
            end else begin : g_mid
                assign dd_adv[g] = !dd_vld[g] || dd_adv[g+1];
            end

            if (g == 0) begin : g_first
                lcnc_dd_stage u_stage (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .adv     (dd_adv[g]),
                    .vld_in  (s_valid),
                    .bcd_in  ('0),
                    .bin_in  (s_card_number),
                    .vld_reg (dd_vld[g]),
                    .bcd_reg (dd_bcd[g]),
                    .bin_reg (dd_bin[g])
                );
            end else begin : g_next
                lcnc_dd_stage u_stage (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .adv     (dd_adv[g]),
                    .vld_in  (dd_vld[g-1]),
                    .bcd_in  (dd_bcd[g-1]),
                    .bin_in  (dd_bin[g-1]),
                    .vld_reg (dd_vld[g]),
                    .bcd_reg (dd_bcd[g]),
                    .bin_reg (dd_bin[g])
                );
            end
        end
    endgenerate

    assign s_ready = dd_adv[0];

    // count digits and form partial Luhn sums
    always_comb begin
        bcd_t   b;
        digit_t d;
        b           = dd_bcd[DD_STAGES-1];
        count_next  = '0;
        sum_lo_next = '0;
        sum_hi_next = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = b[i*DIGIT_W +: DIGIT_W];
            if (d != '0) begin
                count_next = COUNT_W'(i + 1);
            end
            if (i % 2 == 1) begin
                d = luhn_fold(d);
            end
            if (i < HALF_DIGITS) begin
                sum_lo_next = sum_lo_next + PSUM_W'(d);
            end else begin
                sum_hi_next = sum_hi_next + PSUM_W'(d);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s9_vld_reg <= 1'b0;
        end else if (s9_adv) begin
            s9_vld_reg <= dd_vld[DD_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (s9_adv) begin
            s9_bcd_reg    <= dd_bcd[DD_STAGES-1];
            s9_count_reg  <= count_next;
            s9_sum_lo_reg <= sum_lo_next;
            s9_sum_hi_reg <= sum_hi_next;
        end
    end

    // reduce mod 10 and classify
    always_comb begin
        logic [SUM_W-1:0]  total;
        logic [15:0]       prod;
        logic [SUM_W-1:0]  quot;
        logic [SUM_W-1:0]  rem;
        digit_t            lead;
        digit_t            nxt;
        total = SUM_W'(s9_sum_lo_reg) + SUM_W'(s9_sum_hi_reg);
        prod  = 16'(total) * 16'd205;
        quot  = SUM_W'(prod >> 11);
        rem   = total - SUM_W'(16'(quot) * 16'd10);
        ok_next = (rem == '0);

        lead = get_digit(s9_bcd_reg, s9_count_reg - 5'd1);
        nxt  = get_digit(s9_bcd_reg, s9_count_reg - 5'd2);
        class_next = CLASS_INVALID;
        if (s9_count_reg >= 5'd2) begin
            if (lead == 4'd3 && (nxt == 4'd4 || nxt == 4'd7) && s9_count_reg == LEN_AMEX) begin
                class_next = CLASS_AMEX;
            end else if (lead == 4'd5 && (nxt inside {[4'd1:4'd5]})
                         && s9_count_reg == LEN_MC) begin
                class_next = CLASS_MC;
            end else if (lead == 4'd4
                         && (s9_count_reg == LEN_VISA_S || s9_count_reg == LEN_VISA_L)) begin
                class_next = CLASS_VISA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= s9_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_class_reg <= class_next;
            out_ok_reg    <= ok_next;
            out_count_reg <= s9_count_reg;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_card_class  = out_class_reg;
    assign m_checksum_ok = out_ok_reg;
    assign m_digit_count = out_count_reg;

endmodule

`default_nettype wire
